>>> hw/rtl/fat12_cluster_translator_defines.svh
// Assertion macros used by the checker file of the FAT12 cluster translator.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FAT12_CLUSTER_TRANSLATOR_DEFINES_SVH
`define FAT12_CLUSTER_TRANSLATOR_DEFINES_SVH

// Same-cycle implication.
`define F12CT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define F12CT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/f12ct_pkg.sv
// Types and constants of the FAT12 cluster translator.
// No dependencies; used by every module of the block.
package f12ct_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIR_SECS_W = 21;
  localparam int unsigned ENTRY_W    = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_COUNT           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_FAT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRY_COUNT    = 3'd5;

  // Reset values
  localparam int unsigned BPS_RST = 512;
  localparam int unsigned REC_RST = 224;
  localparam logic [15:0] BYTES_PER_SECTOR_RST    = 16'(BPS_RST);
  localparam logic [7:0]  SECTORS_PER_CLUSTER_RST = 8'd1;
  localparam logic [15:0] RESERVED_SECTORS_RST    = 16'd1;
  localparam logic [7:0]  FAT_COUNT_RST           = 8'd2;
  localparam logic [15:0] SECTORS_PER_FAT_RST     = 16'd9;
  localparam logic [15:0] ROOT_ENTRY_COUNT_RST    = 16'(REC_RST);
  localparam logic [DIR_SECS_W-1:0] DIR_SECS_RST =
    DIR_SECS_W'((32 * REC_RST + BPS_RST - 1) / BPS_RST);

  localparam logic [ENTRY_W-1:0] ENTRY_EOC          = 12'hff8;
  localparam logic [ENTRY_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [12:0]       table_addr;
    logic [7:0]        table_byte;
    logic [ENTRY_W-1:0] cluster;
  } f12ct_in_t;

  typedef struct packed {
    logic [31:0]        sector_lba;
    logic [ENTRY_W-1:0] next_cluster;
    logic               end_of_chain;
    logic               bad_cluster;
  } f12ct_out_t;

  typedef struct packed {
    logic [7:0]            sectors_per_cluster;
    logic [15:0]           reserved_sectors;
    logic [7:0]            fat_count;
    logic [15:0]           sectors_per_fat;
    logic [DIR_SECS_W-1:0] dir_sectors;
  } f12ct_cfg_t;

endpackage

>>> hw/rtl/f12ct_dir_div.sv
// Serial divider for the root directory sector count, ceil(dividend / divisor).
// Uses f12ct_pkg; one quotient bit per cycle, result held until the next start.
module f12ct_dir_div import f12ct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIR_SECS_W-1:0] dividend_i,
  input  logic [15:0]           divisor_i,
  output logic                  busy_o,
  output logic [DIR_SECS_W-1:0] quotient_o
);

  localparam int unsigned STEPS = DIR_SECS_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                  busy_q, busy_d;
  logic                  fin_q, fin_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [15:0]           rem_q, rem_d;
  logic [DIR_SECS_W-1:0] quo_q, quo_d;
  logic [15:0]           den_q, den_d;
  logic [DIR_SECS_W-1:0] res_q, res_d;
  logic [16:0]           rem_sh;
  logic [17:0]           diff;

  assign rem_sh = {rem_q, quo_q[DIR_SECS_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      fin_d  = 1'b0;
      cnt_d  = CNT_W'(STEPS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q && fin_q) begin
      // round up on a nonzero remainder; a zero sector size gives zero
      busy_d = 1'b0;
      fin_d  = 1'b0;
      if (den_q == '0) begin
        res_d = '0;
      end else begin
        res_d = quo_q + DIR_SECS_W'(rem_q != '0);
      end
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_d = diff[15:0];
        quo_d = {quo_q[DIR_SECS_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[15:0];
        quo_d = {quo_q[DIR_SECS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
      res_q  <= DIR_SECS_RST;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
      res_q  <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = res_q;

endmodule

>>> hw/rtl/f12ct_pipe.sv
// Three-stage item pipeline of the FAT12 cluster translator with the table store.
// Uses f12ct_pkg; stage 1 captures, stage 2 reads the table and multiplies,
// stage 3 assembles the result and serves as the output register.
module f12ct_pipe import f12ct_pkg::*; #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hold_i,
  input  f12ct_cfg_t cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  f12ct_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output f12ct_out_t out_data_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3, in_fire;

  f12ct_in_t s1_q;

  // stage 2 payload
  logic               op2_q, odd2_q, bad2_q, ok0_q, ok1_q;
  logic signed [21:0] prod_clus2_q, prod_clus_d;
  logic [23:0]        prod_fat2_q, prod_fat_d;
  logic [21:0]        base2_q, base_d;
  logic [7:0]         rd0_q, rd1_q;

  f12ct_out_t out_q, out_d;

  logic [12:0]        off0, off1;
  logic               ok0_d, ok1_d;
  logic [ADDR_W-1:0]  ra0, ra1, wa;
  logic               mem_we, mem_re;
  logic signed [12:0] clus_m2;
  logic signed [21:0] clus_ext, spc_ext;
  logic [15:0]        word;
  logic [ENTRY_W-1:0] next_entry;

  // ready travels back through the stages
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !hold_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_fire;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage 1 -> 2: table access and products
  assign off0  = {1'b0, s1_q.cluster} + 13'(s1_q.cluster >> 1);
  assign off1  = off0 + 13'd1;
  assign ok0_d = 32'(off0) < TABLE_BYTES;
  assign ok1_d = 32'(off1) < TABLE_BYTES;
  assign ra0   = ADDR_W'(off0);
  assign ra1   = ADDR_W'(off1);
  assign wa    = ADDR_W'(s1_q.table_addr);

  assign mem_we = v1_q && en2 && (s1_q.op == OP_WRITE) && (32'(s1_q.table_addr) < TABLE_BYTES);
  assign mem_re = v1_q && en2 && (s1_q.op == OP_TRANSLATE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wa] <= s1_q.table_byte;
    end
    if (mem_re) begin
      rd0_q <= mem[ra0];
      rd1_q <= mem[ra1];
    end
  end

  assign clus_m2     = $signed({1'b0, s1_q.cluster}) - 13'sd2;
  assign clus_ext    = {{9{clus_m2[12]}}, clus_m2};
  assign spc_ext     = $signed({14'd0, cfg_i.sectors_per_cluster});
  assign prod_clus_d = clus_ext * spc_ext;
  assign prod_fat_d  = 24'(cfg_i.fat_count) * 24'(cfg_i.sectors_per_fat);
  assign base_d      = 22'(cfg_i.reserved_sectors) + 22'(cfg_i.dir_sectors);

  always_ff @(posedge clk_i) begin
    if (en1 && in_fire) begin
      s1_q <= in_data_i;
    end
    if (en2) begin
      op2_q        <= s1_q.op;
      odd2_q       <= s1_q.cluster[0];
      bad2_q       <= s1_q.cluster < FIRST_DATA_CLUSTER;
      ok0_q        <= ok0_d;
      ok1_q        <= ok1_d;
      prod_clus2_q <= prod_clus_d;
      prod_fat2_q  <= prod_fat_d;
      base2_q      <= base_d;
    end
    if (en3) begin
      out_q <= out_d;
    end
  end

  // stage 2 -> 3: entry extraction and sector sum
  assign word       = {ok1_q ? rd1_q : 8'd0, ok0_q ? rd0_q : 8'd0};
  assign next_entry = odd2_q ? word[15:4] : word[11:0];

  always_comb begin
    out_d = '0;
    if (op2_q == OP_TRANSLATE) begin
      out_d.sector_lba   = 32'(base2_q) + 32'(prod_fat2_q)
                         + {{10{prod_clus2_q[21]}}, prod_clus2_q};
      out_d.next_cluster = next_entry;
      out_d.end_of_chain = next_entry >= ENTRY_EOC;
      out_d.bad_cluster  = bad2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/fat12_cluster_translator.sv
// FAT12 cluster translator, top level; uses f12ct_pkg, f12ct_dir_div and f12ct_pipe.
// A write item (op 0) stores one allocation table byte and returns an all-zero
// result; a translate item (op 1) returns the cluster's first data sector and
// its 12-bit table entry with end-of-chain and bad-cluster flags. Items flow
// through a three-stage pipeline at one item per cycle while neither the output
// nor the divider stalls it, and a table write is visible to the very next item.
// The table is a single-write, dual-read byte memory of TABLE_BYTES entries,
// not cleared at reset: translate only clusters whose entry bytes were loaded.
// The root directory sector count comes from a bit-serial divider: a write to
// bytes_per_sector or root_entry_count holds in_ready_o low while it is
// recomputed. The configuration port always accepts; write it only while
// no item is in flight.
module fat12_cluster_translator import f12ct_pkg::*; #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  f12ct_in_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output f12ct_out_t            out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0] bytes_per_sector_q;
  logic [7:0]  sectors_per_cluster_q;
  logic [15:0] reserved_sectors_q;
  logic [7:0]  fat_count_q;
  logic [15:0] sectors_per_fat_q;
  logic [15:0] root_entry_count_q;

  logic                  cfg_we;
  logic                  div_start_q, div_start_d;
  logic                  div_busy;
  logic [DIR_SECS_W-1:0] dir_sectors;
  f12ct_cfg_t            cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign div_start_d = cfg_we && ((cfg_index_i == REG_BYTES_PER_SECTOR) ||
                                  (cfg_index_i == REG_ROOT_ENTRY_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_per_sector_q    <= BYTES_PER_SECTOR_RST;
      sectors_per_cluster_q <= SECTORS_PER_CLUSTER_RST;
      reserved_sectors_q    <= RESERVED_SECTORS_RST;
      fat_count_q           <= FAT_COUNT_RST;
      sectors_per_fat_q     <= SECTORS_PER_FAT_RST;
      root_entry_count_q    <= ROOT_ENTRY_COUNT_RST;
      div_start_q           <= 1'b0;
    end else begin
      div_start_q <= div_start_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_BYTES_PER_SECTOR:    bytes_per_sector_q    <= cfg_data_i;
          REG_SECTORS_PER_CLUSTER: sectors_per_cluster_q <= cfg_data_i[7:0];
          REG_RESERVED_SECTORS:    reserved_sectors_q    <= cfg_data_i;
          REG_FAT_COUNT:           fat_count_q           <= cfg_data_i[7:0];
          REG_SECTORS_PER_FAT:     sectors_per_fat_q     <= cfg_data_i;
          REG_ROOT_ENTRY_COUNT:    root_entry_count_q    <= cfg_data_i;
          default: begin
            // drop writes past the register list
          end
        endcase
      end
    end
  end

  f12ct_dir_div u_dir_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ({root_entry_count_q, 5'b00000}),
    .divisor_i  (bytes_per_sector_q),
    .busy_o     (div_busy),
    .quotient_o (dir_sectors)
  );

  assign cfg.sectors_per_cluster = sectors_per_cluster_q;
  assign cfg.reserved_sectors    = reserved_sectors_q;
  assign cfg.fat_count           = fat_count_q;
  assign cfg.sectors_per_fat     = sectors_per_fat_q;
  assign cfg.dir_sectors         = dir_sectors;

  f12ct_pipe #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (div_start_q || div_busy),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/f12ct_checker.sv
// Port-level checks of the FAT12 cluster translator, bound to the top level.
// Uses f12ct_pkg and the assertion macros of fat12_cluster_translator_defines.svh.
`include "fat12_cluster_translator_defines.svh"

module f12ct_checker import f12ct_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input f12ct_out_t           out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i
);

  // a stalled result stays put
  `F12CT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `F12CT_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed")

  // the flag must agree with the entry it reports on
  `F12CT_ASSERT_NOW(a_eoc_match, out_valid_o,
    out_data_o.end_of_chain == (out_data_o.next_cluster >= ENTRY_EOC), "end_of_chain mismatch")

  // a sector size or root size change blocks items while the divider runs
  `F12CT_ASSERT_NEXT(a_div_hold, cfg_valid_i && cfg_ready_o &&
    (cfg_index_i == REG_BYTES_PER_SECTOR || cfg_index_i == REG_ROOT_ENTRY_COUNT),
    !in_ready_o, "items taken during directory size update")

endmodule

bind fat12_cluster_translator f12ct_checker u_f12ct_checker (.*);
